// File: design/plc_pkg.sv
// shared types and constants for the palette lru cache
// used by plc_ctrl, plc_datapath, palette_lru_cache and plc_checker
package plc_pkg;

  // default sizes, handed to the top level as parameter defaults
  localparam int SLOTS_DEF     = 5;
  localparam int TAG_WIDTH_DEF = 32;
  localparam int AGE_WIDTH_DEF = 32;

  // fixed field widths of the channels
  localparam int ID_W         = 32;
  localparam int GAMMA_W      = 3;
  localparam int SLOT_FIELD_W = 3;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic commit;   // resolve the request, update cache state, load result
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_status_t;

endpackage

// File: design/palette_lru_cache.sv
// palette lru cache: fully associative cache of palette ids with lru
// replacement. top level: plc_ctrl and plc_datapath, types from plc_pkg
//
// usage
//   input channel  in_valid / in_stall carries in_palette_id and
//   in_gamma_level; one result transaction per input transaction on
//   out_valid / out_stall with hit, slot, load_needed, evicted, flushed,
//   full_redraw and rejected.
//   cfg_wr_en / cfg_wr_data set direct mode; write only while idle.
//   the accepted request is latched, resolved in the exec state once the
//   result register has room, and its result is held in the output
//   register. the controller latches the request in the idle state and
//   resolves it in the exec state, taking no new request meanwhile, with
//   all tags compared in parallel and the oldest slot found by a min-age
//   tree. a finished result waits in the output register, so a new
//   request is accepted while the receiver stalls; the second result
//   waits in the exec state until the output register frees up.
//   reset empties every slot, clears the age counter and direct mode and
//   forces a flush on the first nonzero cache-mode request.
module palette_lru_cache
  import plc_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF,
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ID_W-1:0]         in_palette_id,
  input  logic [GAMMA_W-1:0]      in_gamma_level,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [SLOT_FIELD_W-1:0] out_slot,
  output logic                    out_load_needed,
  output logic                    out_evicted,
  output logic                    out_flushed,
  output logic                    out_full_redraw,
  output logic                    out_rejected,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // controller
  plc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  plc_datapath #(
    .SLOTS     (SLOTS),
    .TAG_WIDTH (TAG_WIDTH),
    .AGE_WIDTH (AGE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_palette_id   (in_palette_id),
    .in_gamma_level  (in_gamma_level),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_slot        (out_slot),
    .out_load_needed (out_load_needed),
    .out_evicted     (out_evicted),
    .out_flushed     (out_flushed),
    .out_full_redraw (out_full_redraw),
    .out_rejected    (out_rejected)
  );

endmodule

// File: design/plc_ctrl.sv
// controller state machine for the palette lru cache
// depends on plc_pkg for state, command and status types
module plc_ctrl
  import plc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the result register has room
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/plc_datapath.sv
// datapath of the palette lru cache: request latch, slot store, lookup,
// lru victim tree, state update and result register; depends on plc_pkg
module plc_datapath
  import plc_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF,
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_cmd_t                cmd,
  output dp_status_t              status,
  input  logic [ID_W-1:0]         in_palette_id,
  input  logic [GAMMA_W-1:0]      in_gamma_level,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic [SLOT_FIELD_W-1:0] out_slot,
  output logic                    out_load_needed,
  output logic                    out_evicted,
  output logic                    out_flushed,
  output logic                    out_full_redraw,
  output logic                    out_rejected
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEAVES = 1 << SLOT_W;

  // request latch
  logic [TAG_WIDTH-1:0] req_tag_r;
  logic [GAMMA_W-1:0]   req_gamma_r;

  // cache state
  logic                 direct_mode_r;
  logic [SLOTS-1:0]     slot_valid_r, slot_valid_nxt;
  logic [TAG_WIDTH-1:0] slot_tag_r [SLOTS];
  logic [AGE_WIDTH-1:0] slot_age_r [SLOTS];
  logic [AGE_WIDTH-1:0] age_cnt_r;
  logic [GAMMA_W-1:0]   gamma_r;
  logic                 gamma_known_r;

  // result register
  logic                    out_valid_r;
  logic                    hit_r, load_r, evict_r, flush_r, redraw_r, reject_r;
  logic [SLOT_FIELD_W-1:0] slot_r;

  // lookup signals
  logic                 flush;
  logic                 is_zero;
  logic                 cache_op;
  logic [SLOTS-1:0]     eff_valid;
  logic [SLOTS-1:0]     hit_vec;
  logic                 any_hit, any_empty;
  logic [SLOT_W-1:0]    hit_idx, empty_idx, oldest_idx, pick_idx;
  logic [AGE_WIDTH-1:0] age_next;

  // min-age tournament tree, node 1 is the root, leaves from LEAVES up
  logic [AGE_WIDTH-1:0] tr_age [1:2*LEAVES-1];
  logic [SLOT_W-1:0]    tr_idx [1:2*LEAVES-1];

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_tag_r   <= TAG_WIDTH'(in_palette_id);
      req_gamma_r <= in_gamma_level;
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direct_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      direct_mode_r <= cfg_wr_data;
    end
  end

  // request classification
  assign is_zero   = (req_tag_r == '0);
  assign cache_op  = !is_zero && !direct_mode_r;
  assign flush     = !gamma_known_r || (req_gamma_r != gamma_r);
  assign eff_valid = flush ? '0 : slot_valid_r;
  assign age_next  = (flush ? '0 : age_cnt_r) + AGE_WIDTH'(1);

  // parallel tag compare and empty-slot search, lowest index first
  always_comb begin
    hit_vec   = '0;
    any_hit   = 1'b0;
    any_empty = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      hit_vec[i] = eff_valid[i] && (slot_tag_r[i] == req_tag_r);
      if (hit_vec[i]) begin
        any_hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!eff_valid[i]) begin
        any_empty = 1'b1;
        empty_idx = SLOT_W'(i);
      end
    end
  end

  // oldest slot, left child wins ties so the lowest index is kept
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < SLOTS) begin
        tr_age[LEAVES + i] = slot_age_r[i];
      end else begin
        tr_age[LEAVES + i] = '1;
      end
      tr_idx[LEAVES + i] = SLOT_W'(i);
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (tr_age[2*n+1] < tr_age[2*n]) begin
        tr_age[n] = tr_age[2*n+1];
        tr_idx[n] = tr_idx[2*n+1];
      end else begin
        tr_age[n] = tr_age[2*n];
        tr_idx[n] = tr_idx[2*n];
      end
    end
    oldest_idx = tr_idx[1];
  end

  assign pick_idx = any_hit ? hit_idx : (any_empty ? empty_idx : oldest_idx);

  // slot valid bits, flush clears all before the pick is marked
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    if (cmd.commit && cache_op) begin
      if (flush) begin
        slot_valid_nxt = '0;
      end
      slot_valid_nxt[pick_idx] = 1'b1;
    end
  end

  // control part of cache state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r  <= '0;
      age_cnt_r     <= '0;
      gamma_r       <= '0;
      gamma_known_r <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
      if (cmd.commit && cache_op) begin
        age_cnt_r     <= age_next;
        gamma_r       <= req_gamma_r;
        gamma_known_r <= 1'b1;
      end
    end
  end

  // tag and age store, written at the picked slot
  always_ff @(posedge clk) begin
    if (cmd.commit && cache_op) begin
      slot_tag_r[pick_idx] <= req_tag_r;
      slot_age_r[pick_idx] <= age_next;
    end
  end

  // result register
  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r    <= cache_op && any_hit;
      slot_r   <= cache_op ? SLOT_FIELD_W'(pick_idx) : '0;
      load_r   <= !is_zero && (direct_mode_r || !any_hit);
      evict_r  <= cache_op && !any_hit && !any_empty;
      flush_r  <= cache_op && flush;
      redraw_r <= cache_op;
      reject_r <= is_zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_slot        = slot_r;
  assign out_load_needed = load_r;
  assign out_evicted     = evict_r;
  assign out_flushed     = flush_r;
  assign out_full_redraw = redraw_r;
  assign out_rejected    = reject_r;

endmodule

// File: design/plc_checker.sv
// port-level checks for palette_lru_cache, bound to the top level
// depends on plc_pkg for field widths
module plc_port_checks
  import plc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_hit,
  input logic [SLOT_FIELD_W-1:0] out_slot,
  input logic                    out_load_needed,
  input logic                    out_evicted,
  input logic                    out_rejected
);

  // one transaction in flight: accepted input blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // with an empty output register the exec state does not wait and the result shows
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_slot) && $stable(out_hit)))
    else $error("stalled result changed");

  // a hit never loads or evicts, a reject has no hit, no load and slot zero
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_hit && (out_load_needed || out_evicted)) &&
                   !(out_rejected && (out_hit || out_load_needed || out_slot != '0))))
    else $error("inconsistent result fields");

endmodule

bind palette_lru_cache plc_port_checks u_plc_port_checks (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_slot        (out_slot),
  .out_load_needed (out_load_needed),
  .out_evicted     (out_evicted),
  .out_rejected    (out_rejected)
);

// File: tb/plc_checker.sv
// result checker for the palette lru cache: watches both channels and the config port,
// predicts every result transaction from its own model of the cache and compares them.
// depends on plc_pkg for the field widths and the default sizes
module plc_checker
  import plc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [ID_W-1:0]         in_palette_id,
  input  logic [GAMMA_W-1:0]      in_gamma_level,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_hit,
  input  logic [SLOT_FIELD_W-1:0] out_slot,
  input  logic                    out_load_needed,
  input  logic                    out_evicted,
  input  logic                    out_flushed,
  input  logic                    out_full_redraw,
  input  logic                    out_rejected,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  output int                      fail_count,
  output int                      results_pending
);

  localparam int SLOT_COUNT = SLOTS_DEF;
  localparam int TAG_W      = TAG_WIDTH_DEF;
  localparam int AGE_W      = AGE_WIDTH_DEF;
  localparam int SHOW_MAX   = 10;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    load_needed;
    logic                    evicted;
    logic                    flushed;
    logic                    full_redraw;
    logic                    rejected;
  } lookup_result_t;

  // model copy of the cache state and the direct mode register
  logic [TAG_W-1:0]   tag_mem [SLOT_COUNT];
  logic [AGE_W-1:0]   age_mem [SLOT_COUNT];
  logic [AGE_W-1:0]   age_now;
  logic [GAMMA_W-1:0] gamma_now;
  logic               gamma_valid;
  logic               direct_now;

  lookup_result_t expected_results[$];
  int             mismatches;

  // resolve one request against the model cache and update it
  function automatic lookup_result_t lookup_palette(input logic [ID_W-1:0] id,
                                                    input logic [GAMMA_W-1:0] gamma);
    lookup_result_t   r;
    logic [TAG_W-1:0] tag;
    int               pick;
    int               empty;
    int               oldest;
    r      = '0;
    tag    = id;
    pick   = -1;
    empty  = -1;
    oldest = 0;
    if (tag == '0) begin
      r.rejected = 1'b1;
    end else if (direct_now) begin
      r.load_needed = 1'b1;
    end else begin
      r.full_redraw = 1'b1;
      // first request or gamma change empties everything
      if (!gamma_valid || gamma != gamma_now) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          tag_mem[i] = '0;
          age_mem[i] = '0;
        end
        age_now     = '0;
        gamma_now   = gamma;
        gamma_valid = 1'b1;
        r.flushed   = 1'b1;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (pick < 0 && tag_mem[i] == tag) pick = i;
      end
      if (pick >= 0) begin
        r.hit = 1'b1;
      end else begin
        // first empty slot, else smallest age with lowest index on a tie
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (empty < 0) begin
            if (tag_mem[i] == '0) empty = i;
            else if (age_mem[i] < age_mem[oldest]) oldest = i;
          end
        end
        pick          = (empty >= 0) ? empty : oldest;
        r.evicted     = (tag_mem[pick] != '0);
        tag_mem[pick] = tag;
        r.load_needed = 1'b1;
      end
      age_now       = age_now + 1'b1;
      age_mem[pick] = age_now;
      r.slot        = pick[SLOT_FIELD_W-1:0];
    end
    return r;
  endfunction

  // monitor: config writes, result transactions, then request transactions
  always @(posedge clk) begin
    lookup_result_t seen;
    lookup_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tag_mem[i] = '0;
        age_mem[i] = '0;
      end
      age_now     = '0;
      gamma_now   = '0;
      gamma_valid = 1'b0;
      direct_now  = 1'b0;
      mismatches  = 0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en === 1'b1) direct_now = cfg_wr_data;
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen = '{out_hit, out_slot, out_load_needed, out_evicted, out_flushed,
                 out_full_redraw, out_rejected};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("unexpected result transaction at %0t: hit=%b slot=%0d", $realtime,
                     seen.hit, seen.slot);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
              $display({"mismatch at %0t: hit %b/%b slot %0d/%0d load %b/%b evict %b/%b",
                        " flush %b/%b redraw %b/%b reject %b/%b (expected/actual)"},
                       $realtime, want.hit, seen.hit, want.slot, seen.slot,
                       want.load_needed, seen.load_needed, want.evicted, seen.evicted,
                       want.flushed, seen.flushed, want.full_redraw, seen.full_redraw,
                       want.rejected, seen.rejected);
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        expected_results.push_back(lookup_palette(in_palette_id, in_gamma_level));
    end
    fail_count      <= mismatches;
    results_pending <= expected_results.size();
  end

endmodule

// File: tb/tb_palette_lru_cache.sv
// testbench top for the palette lru cache: clock, reset, stimulus and verdict.
// depends on plc_pkg, palette_lru_cache and plc_checker
module tb_palette_lru_cache;
  import plc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_MAX    = 10;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [ID_W-1:0]         in_palette_id;
  logic [GAMMA_W-1:0]      in_gamma_level;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_hit;
  logic [SLOT_FIELD_W-1:0] out_slot;
  logic                    out_load_needed;
  logic                    out_evicted;
  logic                    out_flushed;
  logic                    out_full_redraw;
  logic                    out_rejected;
  logic                    cfg_wr_en;
  logic                    cfg_wr_data;

  int fail_count;
  int results_pending;
  int cycle_count;
  int burst_left;
  bit calm;

  logic [ID_W-1:0]    id_pool [POOL_MAX];
  int                 pool_size;
  logic [GAMMA_W-1:0] cur_gamma;

  palette_lru_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_palette_id  (in_palette_id),
    .in_gamma_level (in_gamma_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_load_needed(out_load_needed),
    .out_evicted    (out_evicted),
    .out_flushed    (out_flushed),
    .out_full_redraw(out_full_redraw),
    .out_rejected   (out_rejected),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  plc_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_palette_id  (in_palette_id),
    .in_gamma_level (in_gamma_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_load_needed(out_load_needed),
    .out_evicted    (out_evicted),
    .out_flushed    (out_flushed),
    .out_full_redraw(out_full_redraw),
    .out_rejected   (out_rejected),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern, switching at random among four styles
  always @(posedge clk) begin
    int stall_tick;
    int stall_style;
    if (stall_tick % 64 == 0) stall_style = $urandom_range(0, 3);
    stall_tick++;
    case (stall_style)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= (stall_tick % 5 < 2);
      end
    endcase
  end

  // one request transaction, with a random gap at the start of each burst
  task automatic send_request(input logic [ID_W-1:0] id, input logic [GAMMA_W-1:0] gamma);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_palette_id  <= id;
    in_gamma_level <= gamma;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every expected result has come, plus the pipeline depth
  task automatic wait_for_drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // direct mode write while the block is idle
  task automatic write_direct_mode(input logic value);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // fresh set of nonzero ids to draw hits and evictions from
  task automatic refill_pool();
    pool_size = $urandom_range(2, POOL_MAX);
    for (int i = 0; i < POOL_MAX; i++) begin
      id_pool[i] = ($urandom_range(0, 2) == 0) ? ID_W'($urandom_range(1, 16)) : $urandom();
      if (id_pool[i] == '0) id_pool[i] = 'd1;
    end
  endtask

  // random requests: mostly pool ids with a steady gamma, some noise
  task automatic random_phase(input int count);
    int               pick;
    logic [ID_W-1:0]  id;
    refill_pool();
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 149) == 0) wait_for_drain();
      if ($urandom_range(0, 199) == 0) id_pool[$urandom_range(0, pool_size - 1)] = $urandom();
      if ($urandom_range(0, 49) == 0) cur_gamma = GAMMA_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 3) id = '0;
      else if (pick < 8) id = $urandom();
      else id = id_pool[$urandom_range(0, pool_size - 1)];
      send_request(id, cur_gamma);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_palette_id  = '0;
    in_gamma_level = '0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    cycle_count    = 0;
    burst_left     = 0;
    calm           = 1'b0;
    cur_gamma      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero id before the first flush, first flush on an empty cache
    write_direct_mode(1'b0);
    send_request('0, 3'd0);
    send_request(32'hFFFF_FFFF, 3'd0);
    send_request(32'hFFFF_FFFF, 3'd0);
    send_request(32'h0000_0001, 3'd0);
    send_request(32'h8000_0000, 3'd0);
    send_request(32'h1234_5678, 3'd0);
    send_request(32'h5A5A_5A5A, 3'd0);
    // full cache: evict the least recent, then hit a survivor
    send_request(32'h0000_0002, 3'd0);
    send_request(32'h0000_0001, 3'd0);
    send_request(32'hA5A5_A5A5, 3'd0);
    // zero id with a new gamma changes nothing; a gamma change flushes
    send_request('0, 3'd7);
    send_request(32'h0000_0001, 3'd7);
    send_request(32'h0000_0001, 3'd7);
    send_request(32'h0000_0003, 3'd4);
    send_request(32'h0000_0004, 3'd4);
    // direct mode bypass, gamma ignored
    write_direct_mode(1'b1);
    send_request('0, 3'd0);
    send_request(32'hFFFF_FFFF, 3'd5);
    send_request(32'h0000_0003, 3'd2);
    send_request(32'h0000_0001, 3'd4);
    // back to cache mode: state kept, gamma change flushes
    write_direct_mode(1'b0);
    send_request(32'h0000_0004, 3'd4);
    send_request(32'h0000_0001, 3'd2);
    send_request(32'h0000_0001, 3'd2);
    send_request(32'hFFFF_FFFE, 3'd2);

    // random phases over both register values
    cur_gamma = 3'd2;
    random_phase(650);
    write_direct_mode(1'b1);
    random_phase(200);
    write_direct_mode(1'b0);
    random_phase(650);
    write_direct_mode(1'b1);
    random_phase(150);
    write_direct_mode(1'b0);
    random_phase(350);

    wait_for_drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/plc_pkg.sv
design/plc_ctrl.sv
design/plc_datapath.sv
design/palette_lru_cache.sv
design/plc_checker.sv
tb/plc_checker.sv
tb/tb_palette_lru_cache.sv
